// ===== hdl/pressure_depth_spike_filter_defines.svh =====
// Assertion helpers shared by the filter RTL.
// Each one samples on clk and is off while rst is high.
`ifndef PRESSURE_DEPTH_SPIKE_FILTER_DEFINES_SVH
`define PRESSURE_DEPTH_SPIKE_FILTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PDSF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PDSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pdsf_pkg.sv =====
`default_nettype none

package pdsf_pkg;

  // Field and register widths
  localparam int unsigned RAW_W    = 24;
  localparam int unsigned VAR_W    = 32;
  localparam int unsigned P_W      = 27;
  localparam int unsigned SCALE_W  = 24;
  localparam int unsigned GAIN_W   = 24;
  localparam int unsigned REJ_W    = 16;
  localparam int unsigned CNT_W    = 17;
  localparam int unsigned DEPTH_W  = 32;
  localparam int unsigned DVAR_W   = 48;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned MUL_W    = 32;
  localparam int unsigned PROD_W   = 64;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 27;

  // Saturation limits
  localparam logic [P_W-1:0]   P_MAX   = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Register reset values
  localparam logic [SCALE_W-1:0] SCALE_RST = 24'd65536;
  localparam logic [P_W-1:0]     DELTA_RST = 27'd0;
  localparam logic [REJ_W-1:0]   MAXREJ_RST = 16'd5;
  localparam logic [P_W-1:0]     ATM_RST   = 27'd101325;
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 24'd1668000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE  = 3'd0,
    CFG_DELTA  = 3'd1,
    CFG_MAXREJ = 3'd2,
    CFG_ATM    = 3'd3,
    CFG_GAIN   = 3'd4
  } cfg_idx_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_DEPTH  = 2'd0,
    STATUS_SPIKE  = 2'd1,
    STATUS_CAL    = 2'd2,
    STATUS_NODATA = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAL,
    ST_PMUL,
    ST_PRES,
    ST_DECIDE,
    ST_MMUL,
    ST_DEPTH,
    ST_KSQ,
    ST_VLO,
    ST_VHI,
    ST_OUT
  } state_t;

  // Operand pair for the shared multiplier
  typedef struct packed {
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_op_t;

endpackage

`default_nettype wire

// ===== hdl/pdsf_mul.sv =====
`default_nettype none

module pdsf_mul (
  input  wire logic                         clk,
  input  wire pdsf_pkg::mul_op_t            op,
  output logic [pdsf_pkg::PROD_W-1:0]       prod
);

  // Register one unsigned 32x32 product per cycle
  always_ff @(posedge clk) begin
    prod <= {{(pdsf_pkg::PROD_W-pdsf_pkg::MUL_W){1'b0}}, op.a}
          * {{(pdsf_pkg::PROD_W-pdsf_pkg::MUL_W){1'b0}}, op.b};
  end

endmodule

`default_nettype wire

// ===== hdl/pressure_depth_spike_filter.sv =====
// Pressure to depth converter with spike rejection and zero calibration.
//
// Input beats arrive on s_* (tuser = command, tdata = raw pressure and raw
// variance); one result beat per input leaves on m_* (tuser = status,
// tdata = depth, depth variance, reference pressure). The cfg_* port
// writes the five setting registers; write them only while no beat is
// in flight.
//
// All arithmetic runs through one registered 32x32 multiplier under a
// small sequencer, so s_tready is high only between beats and a new beat
// is taken only after the previous result has been loaded. A pressure
// sample uses the multiplier six times, a rejected spike uses it twice
// and a calibrate command does not use it at all.
//
// A finished result sits in the output register while the next beat is
// being worked on; if m_tready stays low the sequencer holds in its last
// step until the output register frees up. rst (synchronous) restores the
// register defaults, forgets the last sample and the calibration.
`default_nettype none

`include "pressure_depth_spike_filter_defines.svh"

module pressure_depth_spike_filter (
  input  wire logic        clk,
  input  wire logic        rst,
  // settings write port
  input  wire logic                                 cfg_we,
  input  wire logic [pdsf_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  wire logic [pdsf_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,   // [23:0] pressure_raw, [55:24] variance_raw
  input  wire logic [0:0]  s_tuser,   // [0] command
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [111:0]     m_tdata,   // [31:0] depth_mm, [79:32] depth_variance,
                                      // [106:80] ref_pa, [111:107] zero
  output logic [1:0]       m_tuser    // [1:0] status
);

  localparam int unsigned P_W     = pdsf_pkg::P_W;
  localparam int unsigned MUL_W   = pdsf_pkg::MUL_W;
  localparam int unsigned PROD_W  = pdsf_pkg::PROD_W;
  localparam int unsigned CNT_W   = pdsf_pkg::CNT_W;
  localparam int unsigned DEPTH_W = pdsf_pkg::DEPTH_W;
  localparam int unsigned DVAR_W  = pdsf_pkg::DVAR_W;

  // Settings
  logic [pdsf_pkg::SCALE_W-1:0] raw_scale;
  logic [P_W-1:0]               spike_limit;
  logic [pdsf_pkg::REJ_W-1:0]   max_rejections;
  logic [P_W-1:0]               atm_ref;
  logic [pdsf_pkg::GAIN_W-1:0]  depth_gain;

  // Filter state
  logic [P_W-1:0]   last_pressure;
  logic             have_last;
  logic [CNT_W-1:0] reject_count;
  logic             is_calibrated;
  logic [P_W-1:0]   calibrated_pressure;

  // Current beat and working values
  logic [pdsf_pkg::RAW_W-1:0]    raw;
  logic [pdsf_pkg::VAR_W-1:0]    var_raw;
  logic [P_W-1:0]                p;
  logic [MUL_W-1:0]              k;
  logic [P_W-1:0]                mag;
  logic                          below;
  logic [MUL_W-1:0]              k2_hi;
  logic [PROD_W:0]               lo_sum;

  // Finished result
  pdsf_pkg::status_t   res_status;
  logic [DEPTH_W-1:0]  res_depth;
  logic [DVAR_W-1:0]   res_dvar;
  logic [P_W-1:0]      res_ref;

  // Output register
  pdsf_pkg::status_t   out_status;
  logic [DEPTH_W-1:0]  out_depth;
  logic [DVAR_W-1:0]   out_dvar;
  logic [P_W-1:0]      out_ref;

  pdsf_pkg::state_t   state, state_next;
  pdsf_pkg::mul_op_t  mul_op;
  logic [PROD_W-1:0]  prod;
  logic               out_load;

  pdsf_mul u_mul (
    .clk  (clk),
    .op   (mul_op),
    .prod (prod)
  );

  // Datapath helpers
  logic [P_W-1:0]    cur_ref;
  logic [47:0]       p_round;
  logic [P_W-1:0]    p_sat;
  logic [47:0]       k_round;
  logic [P_W-1:0]    diff;
  logic              spike;
  logic [CNT_W-1:0]  cnt_inc;
  logic              reject;
  logic [51:0]       m_round;
  logic [27:0]       m_mag;
  logic [PROD_W:0]   v_total;

  always_comb begin
    cur_ref = is_calibrated ? calibrated_pressure : atm_ref;
    // pressure in pascals, rounded and clamped
    p_round = prod[47:0] + 48'd32768;
    p_sat   = (p_round[47:43] != '0) ? pdsf_pkg::P_MAX : p_round[42:16];
    // gain per raw unit, Q8.24
    k_round = prod[47:0] + 48'd32768;
    // spike test against the last accepted sample
    diff    = (p >= last_pressure) ? p - last_pressure : last_pressure - p;
    spike   = (spike_limit != '0) && have_last && (diff > spike_limit);
    cnt_inc = (reject_count == pdsf_pkg::CNT_MAX) ? reject_count : reject_count + 1'b1;
    reject  = spike && (cnt_inc <= {1'b0, max_rejections});
    // depth magnitude, rounded
    m_round = prod[51:0] + 52'd8388608;
    m_mag   = m_round[51:24];
    // combine high partial product with the rounded low one
    v_total = {1'b0, prod} + {{(PROD_W-32){1'b0}}, lo_sum[PROD_W:32]};
  end

  // Sequencer: next state, multiplier operands and handshake
  always_comb begin
    state_next = state;
    mul_op     = '{a: '0, b: '0};
    s_tready   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      pdsf_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = s_tuser[0] ? pdsf_pkg::ST_CAL : pdsf_pkg::ST_PMUL;
        end
      end
      pdsf_pkg::ST_CAL: begin
        state_next = pdsf_pkg::ST_OUT;
      end
      pdsf_pkg::ST_PMUL: begin
        mul_op     = '{a: {8'd0, raw}, b: {8'd0, raw_scale}};
        state_next = pdsf_pkg::ST_PRES;
      end
      pdsf_pkg::ST_PRES: begin
        mul_op     = '{a: {8'd0, raw_scale}, b: {8'd0, depth_gain}};
        state_next = pdsf_pkg::ST_DECIDE;
      end
      pdsf_pkg::ST_DECIDE: begin
        state_next = reject ? pdsf_pkg::ST_OUT : pdsf_pkg::ST_MMUL;
      end
      pdsf_pkg::ST_MMUL: begin
        mul_op     = '{a: {5'd0, mag}, b: {8'd0, depth_gain}};
        state_next = pdsf_pkg::ST_DEPTH;
      end
      pdsf_pkg::ST_DEPTH: begin
        mul_op     = '{a: k, b: k};
        state_next = pdsf_pkg::ST_KSQ;
      end
      pdsf_pkg::ST_KSQ: begin
        mul_op     = '{a: var_raw, b: prod[MUL_W-1:0]};
        state_next = pdsf_pkg::ST_VLO;
      end
      pdsf_pkg::ST_VLO: begin
        mul_op     = '{a: var_raw, b: k2_hi};
        state_next = pdsf_pkg::ST_VHI;
      end
      pdsf_pkg::ST_VHI: begin
        state_next = pdsf_pkg::ST_OUT;
      end
      pdsf_pkg::ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = pdsf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pdsf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pdsf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Settings writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_scale      <= pdsf_pkg::SCALE_RST;
      spike_limit    <= pdsf_pkg::DELTA_RST;
      max_rejections <= pdsf_pkg::MAXREJ_RST;
      atm_ref        <= pdsf_pkg::ATM_RST;
      depth_gain     <= pdsf_pkg::GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pdsf_pkg::CFG_SCALE:  raw_scale      <= cfg_data[pdsf_pkg::SCALE_W-1:0];
        pdsf_pkg::CFG_DELTA:  spike_limit    <= cfg_data[P_W-1:0];
        pdsf_pkg::CFG_MAXREJ: max_rejections <= cfg_data[pdsf_pkg::REJ_W-1:0];
        pdsf_pkg::CFG_ATM:    atm_ref        <= cfg_data[P_W-1:0];
        pdsf_pkg::CFG_GAIN:   depth_gain     <= cfg_data[pdsf_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Filter state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      last_pressure       <= '0;
      have_last           <= 1'b0;
      reject_count        <= '0;
      is_calibrated       <= 1'b0;
      calibrated_pressure <= '0;
    end else begin
      if (state == pdsf_pkg::ST_CAL && have_last) begin
        calibrated_pressure <= last_pressure;
        is_calibrated       <= 1'b1;
        reject_count        <= '0;
      end
      if (state == pdsf_pkg::ST_DECIDE) begin
        if (reject) begin
          reject_count <= cnt_inc;
        end else begin
          reject_count  <= '0;
          last_pressure <= p;
          have_last     <= 1'b1;
        end
      end
    end
  end

  // Working registers and result
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      raw     <= s_tdata[23:0];
      var_raw <= s_tdata[55:24];
    end
    unique case (state)
      pdsf_pkg::ST_CAL: begin
        res_status <= have_last ? pdsf_pkg::STATUS_CAL : pdsf_pkg::STATUS_NODATA;
        res_ref    <= have_last ? last_pressure : cur_ref;
        res_depth  <= '0;
        res_dvar   <= '0;
      end
      pdsf_pkg::ST_PRES: begin
        p <= p_sat;
      end
      pdsf_pkg::ST_DECIDE: begin
        k          <= k_round[47:16];
        mag        <= (p >= cur_ref) ? p - cur_ref : cur_ref - p;
        below      <= p < cur_ref;
        res_ref    <= cur_ref;
        res_status <= reject ? pdsf_pkg::STATUS_SPIKE : pdsf_pkg::STATUS_DEPTH;
        res_depth  <= '0;
        res_dvar   <= '0;
      end
      pdsf_pkg::ST_DEPTH: begin
        res_depth <= below ? {4'd0, m_mag} : DEPTH_W'(0) - {4'd0, m_mag};
      end
      pdsf_pkg::ST_KSQ: begin
        k2_hi <= prod[PROD_W-1:MUL_W];
      end
      pdsf_pkg::ST_VLO: begin
        lo_sum <= {1'b0, prod} + (65'd1 << 47);
      end
      pdsf_pkg::ST_VHI: begin
        res_dvar <= v_total[PROD_W] ? '1 : v_total[PROD_W-1:16];
      end
      default: ;
    endcase
  end

  // Output register: load a finished result, drop the beat once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status;
      out_depth  <= res_depth;
      out_dvar   <= res_dvar;
      out_ref    <= res_ref;
    end
  end

  assign m_tdata = {5'd0, out_ref, out_dvar, out_depth};
  assign m_tuser = out_status;

  // Checks
  `PDSF_ASSERT_NEXT(a_accept_starts_work, s_tvalid && s_tready,
    state == pdsf_pkg::ST_PMUL || state == pdsf_pkg::ST_CAL,
    "accepted beat did not start the sequencer")
  `PDSF_ASSERT_SAME(a_spike_count_bounded,
    state == pdsf_pkg::ST_OUT && res_status == pdsf_pkg::STATUS_SPIKE,
    (reject_count != '0) && (reject_count <= ({1'b0, max_rejections})),
    "spike rejected with reject count out of range")
  `PDSF_ASSERT_SAME(a_non_depth_zero,
    state == pdsf_pkg::ST_OUT && res_status != pdsf_pkg::STATUS_DEPTH,
    res_depth == '0 && res_dvar == '0,
    "non-depth result carries depth or variance")
  `PDSF_ASSERT_SAME(a_cal_latched,
    state == pdsf_pkg::ST_OUT && res_status == pdsf_pkg::STATUS_CAL,
    is_calibrated && have_last && res_ref == calibrated_pressure,
    "calibrated result disagrees with latched reference")

endmodule

`default_nettype wire

// ===== tb/sv/tb_pressure_depth_spike_filter.sv =====
module tb_pressure_depth_spike_filter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RAW_W      = pdsf_pkg::RAW_W;
  localparam int unsigned VAR_W      = pdsf_pkg::VAR_W;
  localparam int unsigned P_W        = pdsf_pkg::P_W;
  localparam int unsigned SCALE_W    = pdsf_pkg::SCALE_W;
  localparam int unsigned GAIN_W     = pdsf_pkg::GAIN_W;
  localparam int unsigned REJ_W      = pdsf_pkg::REJ_W;
  localparam int unsigned CNT_W      = pdsf_pkg::CNT_W;
  localparam int unsigned DEPTH_W    = pdsf_pkg::DEPTH_W;
  localparam int unsigned DVAR_W     = pdsf_pkg::DVAR_W;
  localparam int unsigned CFG_IDX_W  = pdsf_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W = pdsf_pkg::CFG_DATA_W;

  localparam logic                 CMD_SAMPLE    = 1'b0;
  localparam logic                 CMD_CALIBRATE = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 3'd7;   // unmapped register index
  localparam int         HOLD_CYCLES   = 400;
  localparam int         LIMIT_CYCLES  = 400000;
  localparam int         PHASES        = 8;
  localparam int         PHASE_ITEMS   = 200;
  localparam longint     RAW_TOP       = 16777215;

  // One expected result beat
  typedef struct packed {
    pdsf_pkg::status_t    status;
    logic [DEPTH_W-1:0]   depth;
    logic [DVAR_W-1:0]    dvar;
    logic [P_W-1:0]       refp;
  } depth_result_t;

  // Depth predictor with its own copy of the settings and filter state
  class depth_scoreboard;
    logic [SCALE_W-1:0] scale;
    logic [P_W-1:0]     max_delta;
    logic [REJ_W-1:0]   max_rej;
    logic [P_W-1:0]     atm;
    logic [GAIN_W-1:0]  gain;
    logic [P_W-1:0]     last_p;
    bit                 have_last;
    logic [CNT_W-1:0]   rej_cnt;
    bit                 calibrated;
    logic [P_W-1:0]     cal_p;
    depth_result_t      pending_depths[$];
    int                 errors;

    function new();
      scale      = pdsf_pkg::SCALE_RST;
      max_delta  = pdsf_pkg::DELTA_RST;
      max_rej    = pdsf_pkg::MAXREJ_RST;
      atm        = pdsf_pkg::ATM_RST;
      gain       = pdsf_pkg::GAIN_RST;
      last_p     = '0;
      have_last  = 1'b0;
      rej_cnt    = '0;
      calibrated = 1'b0;
      cal_p      = '0;
      errors     = 0;
    endfunction

    function void apply_setting(logic [CFG_IDX_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
      case (addr)
        pdsf_pkg::CFG_SCALE:  scale     = value[SCALE_W-1:0];
        pdsf_pkg::CFG_DELTA:  max_delta = value[P_W-1:0];
        pdsf_pkg::CFG_MAXREJ: max_rej   = value[REJ_W-1:0];
        pdsf_pkg::CFG_ATM:    atm       = value[P_W-1:0];
        pdsf_pkg::CFG_GAIN:   gain      = value[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [P_W-1:0] zero_reference();
      return calibrated ? cal_p : atm;
    endfunction

    // Predict the result of one accepted input beat
    function void note_sample(logic cmd, logic [55:0] data);
      logic [RAW_W-1:0] raw;
      logic [VAR_W-1:0] vr;
      logic [63:0]      pw;
      logic [P_W-1:0]   p;
      logic [P_W-1:0]   diff;
      logic [P_W-1:0]   refp;
      logic [P_W-1:0]   mag;
      logic [63:0]      m;
      logic [63:0]      k;
      logic [127:0]     vprod;
      depth_result_t    r;
      raw      = data[23:0];
      vr       = data[55:24];
      r.status = pdsf_pkg::STATUS_DEPTH;
      r.depth  = '0;
      r.dvar   = '0;
      r.refp   = zero_reference();

      // Calibrate: latch the last pressure, or report that none exists
      if (cmd == CMD_CALIBRATE) begin
        if (have_last) begin
          cal_p      = last_p;
          calibrated = 1'b1;
          rej_cnt    = '0;
          r.status   = pdsf_pkg::STATUS_CAL;
          r.refp     = cal_p;
        end else begin
          r.status = pdsf_pkg::STATUS_NODATA;
        end
        pending_depths.push_back(r);
        return;
      end

      // Scale to pascals, saturate
      pw = ({40'd0, raw} * {40'd0, scale} + 64'd32768) >> 16;
      p  = (pw > {37'd0, pdsf_pkg::P_MAX}) ? pdsf_pkg::P_MAX : pw[P_W-1:0];

      // Spike test with forced accept after too many rejections
      if (max_delta != '0 && have_last) begin
        diff = (p > last_p) ? p - last_p : last_p - p;
        if (diff > max_delta) begin
          if (rej_cnt != pdsf_pkg::CNT_MAX) rej_cnt = rej_cnt + 1'b1;
          if (rej_cnt <= {1'b0, max_rej}) begin
            r.status = pdsf_pkg::STATUS_SPIKE;
            pending_depths.push_back(r);
            return;
          end
        end
      end
      rej_cnt   = '0;
      last_p    = p;
      have_last = 1'b1;

      // Depth with rounding and saturation
      refp   = zero_reference();
      r.refp = refp;
      mag    = (p > refp) ? p - refp : refp - p;
      m      = ({37'd0, mag} * {40'd0, gain} + 64'd8388608) >> 24;
      if (p < refp) r.depth = (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
      else r.depth = (m > 64'h8000_0000) ? 32'h8000_0000 : -m[31:0];

      // Variance through the squared mm-per-raw-unit factor
      k     = ({40'd0, scale} * {40'd0, gain} + 64'd32768) >> 16;
      vprod = {96'd0, vr} * {64'd0, k * k} + (128'd1 << 47);
      r.dvar = (|vprod[127:96]) ? {DVAR_W{1'b1}} : vprod[95:48];
      pending_depths.push_back(r);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch %s: got %0h expected %0h", what, got, want);
    endtask

    // Compare one accepted result beat with the oldest prediction
    task check_depth(logic [1:0] user, logic [111:0] data);
      depth_result_t e;
      if (pending_depths.size() == 0) begin
        report_mismatch("unexpected result beat", {62'd0, user}, 64'd0);
        return;
      end
      e = pending_depths.pop_front();
      if (user !== e.status) report_mismatch("status", {62'd0, user}, {62'd0, e.status});
      if (data[31:0] !== e.depth) report_mismatch("depth_mm", {32'd0, data[31:0]},
                                                  {32'd0, e.depth});
      if (data[79:32] !== e.dvar) report_mismatch("depth_variance", {16'd0, data[79:32]},
                                                  {16'd0, e.dvar});
      if (data[106:80] !== e.refp) report_mismatch("ref_pa",
                                                   {37'd0, data[106:80]}, {37'd0, e.refp});
      if (data[111:107] !== 5'd0) report_mismatch("tdata padding", {59'd0, data[111:107]},
                                                  64'd0);
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [55:0]           s_tdata;    // [23:0] pressure_raw, [55:24] variance_raw
  logic [0:0]            s_tuser;    // [0] command
  logic                  m_tvalid;
  logic                  m_tready;
  logic [111:0]          m_tdata;    // [31:0] depth_mm, [79:32] depth_variance,
                                     // [106:80] ref_pa, [111:107] zero
  logic [1:0]            m_tuser;    // [1:0] status

  depth_scoreboard sb;
  int              burst_left;
  bit              hold_request;

  pressure_depth_spike_filter dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #10 clk = ~clk;

  // Watch both handshakes
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_sample(s_tuser[0], s_tdata);
      if (m_tvalid && m_tready) sb.check_depth(m_tuser, m_tdata);
    end
  end

  // Receiver: random stall pattern in spans of random length, plus long holds
  initial begin : receiver
    int mode;
    int span;
    int hold_left;
    mode      = 0;
    span      = 0;
    hold_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(16, 96);
        end
        span--;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 1) == 1);
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (span % 3 == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  // Write one register, then wait with the enable low before returning
  task automatic write_reg(logic [CFG_IDX_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= value;
    @(posedge clk);
    sb.apply_setting(addr, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Offer one beat inside the current burst; open a new burst after a gap
  task automatic send_paced(logic cmd, logic [RAW_W-1:0] raw, logic [VAR_W-1:0] vr);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {vr, raw};
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop offering and wait for every predicted result
  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    // let the last accepted beat reach the scoreboard first
    @(posedge clk);
    while (sb.pending_depths.size() != 0) @(posedge clk);
  endtask

  function automatic longint clamp_raw(longint x);
    if (x < 0) return 0;
    if (x > RAW_TOP) return RAW_TOP;
    return x;
  endfunction

  task automatic run_directed();
    // Defaults: no data yet, field extremes, depth exactly zero
    send_paced(CMD_CALIBRATE, 24'hFFFFFF, 32'hFFFFFFFF);
    send_paced(CMD_SAMPLE, 24'h0, 32'h0);
    send_paced(CMD_SAMPLE, 24'hFFFFFF, 32'hFFFFFFFF);
    send_paced(CMD_SAMPLE, 24'd101325, 32'd1);
    send_paced(CMD_CALIBRATE, 24'h0, 32'h0);
    send_paced(CMD_SAMPLE, 24'd90000, 32'd12345);
    drain();

    // Full-scale settings, upper data bits masked off; spikes then forced accept
    write_reg(pdsf_pkg::CFG_SCALE, 27'h7FFFFFF);
    write_reg(pdsf_pkg::CFG_GAIN, 27'h7FFFFFF);
    write_reg(pdsf_pkg::CFG_ATM, 27'h7FFFFFF);
    write_reg(pdsf_pkg::CFG_DELTA, 27'd1000);
    write_reg(pdsf_pkg::CFG_MAXREJ, 27'h7FF0002);
    write_reg(CFG_SPARE, 27'h7FFFFFF);
    send_paced(CMD_SAMPLE, 24'hFFFFFF, 32'hFFFFFFFF);
    send_paced(CMD_SAMPLE, 24'hFFFFFF, 32'hFFFFFFFF);
    send_paced(CMD_SAMPLE, 24'hFFFFFF, 32'hFFFFFFFF);
    send_paced(CMD_SAMPLE, 24'hFFFFFF, 32'h0);
    send_paced(CMD_SAMPLE, 24'h0, 32'h0);
    send_paced(CMD_CALIBRATE, 24'h123456, 32'hDEADBEEF);
    send_paced(CMD_SAMPLE, 24'hFFFFFE, 32'h80000000);
    drain();

    // Zero scale and gain, widest threshold, no tolerance
    write_reg(pdsf_pkg::CFG_SCALE, 27'h0);
    write_reg(pdsf_pkg::CFG_GAIN, 27'h0);
    write_reg(pdsf_pkg::CFG_DELTA, 27'h7FFFFFF);
    write_reg(pdsf_pkg::CFG_MAXREJ, 27'h0);
    send_paced(CMD_SAMPLE, 24'd12345, 32'd777);
    send_paced(CMD_SAMPLE, 24'hFFFFFF, 32'hFFFFFFFF);
    drain();

    // Tightest threshold: every jump is forced through at once
    write_reg(pdsf_pkg::CFG_SCALE, 27'd65536);
    write_reg(pdsf_pkg::CFG_GAIN, 27'd1668000);
    write_reg(pdsf_pkg::CFG_DELTA, 27'd1);
    write_reg(pdsf_pkg::CFG_ATM, 27'd0);
    send_paced(CMD_SAMPLE, 24'd500, 32'd100);
    send_paced(CMD_SAMPLE, 24'd502, 32'd100);
    send_paced(CMD_CALIBRATE, 24'd0, 32'd0);
    send_paced(CMD_SAMPLE, 24'd501, 32'd100);
    send_paced(CMD_SAMPLE, 24'd503, 32'd100);
    drain();
  endtask

  // One random phase: pick settings, then mostly a pressure walk with spikes
  task automatic run_phase(int ph, int n_items, int hold_at);
    longint           scale_l;
    longint           k;
    longint           delta_l;
    longint           walk;
    longint           step;
    logic [P_W-1:0]   v;
    logic             cmd;
    logic [RAW_W-1:0] raw;
    logic [VAR_W-1:0] vr;
    int               r;
    drain();

    case ($urandom_range(0, 3))
      0: scale_l = 65536;
      1: scale_l = longint'($urandom_range(1, 16777215));
      2: scale_l = longint'($urandom_range(4096, 262144));
      default: scale_l = 16777215;
    endcase
    k = longint'($urandom_range(1, 1 << $urandom_range(0, 18)));
    if (ph == 0 || $urandom_range(0, 4) == 0) begin
      delta_l = 0;
    end else begin
      delta_l = (k * scale_l) >> 16;
      if (delta_l < 1) delta_l = 1;
      if (delta_l > longint'(pdsf_pkg::P_MAX)) delta_l = longint'(pdsf_pkg::P_MAX);
    end

    v = P_W'($urandom);
    v[23:0] = scale_l[23:0];
    write_reg(pdsf_pkg::CFG_SCALE, v);
    write_reg(pdsf_pkg::CFG_DELTA, delta_l[26:0]);
    v = P_W'($urandom);
    case ($urandom_range(0, 3))
      0: v[15:0] = 16'd0;
      1: v[15:0] = REJ_W'($urandom_range(1, 8));
      2: v[15:0] = 16'hFFFF;
      default: v[15:0] = REJ_W'($urandom);
    endcase
    write_reg(pdsf_pkg::CFG_MAXREJ, v);
    if ($urandom_range(0, 2) == 0) write_reg(pdsf_pkg::CFG_ATM, 27'd101325);
    else write_reg(pdsf_pkg::CFG_ATM, CFG_DATA_W'($urandom_range(0, 134217727)));
    v = P_W'($urandom);
    case ($urandom_range(0, 4))
      0: v[23:0] = 24'd1668000;
      1: v[23:0] = 24'hFFFFFF;
      2: v[23:0] = GAIN_W'($urandom_range(0, 255));
      default: v[23:0] = GAIN_W'($urandom);
    endcase
    write_reg(pdsf_pkg::CFG_GAIN, v);
    if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));

    walk = longint'($urandom_range(0, 16777215));
    for (int i = 0; i < n_items; i++) begin
      // Long receiver hold while the sender keeps offering
      if (i == hold_at) begin
        hold_request = 1'b1;
        burst_left   = 80;
      end
      r  = $urandom_range(0, 99);
      vr = $urandom;
      if ($urandom_range(0, 9) == 0) vr = $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'h0;
      if (r < 8) begin
        cmd = CMD_CALIBRATE;
        raw = RAW_W'($urandom);
      end else if (r < 80) begin
        cmd = CMD_SAMPLE;
        if ($urandom_range(0, 5) == 0) begin
          // spike off the walk; the walk itself stays put
          step = k * longint'($urandom_range(2, 64));
          if ($urandom_range(0, 1)) step = -step;
          raw = RAW_W'(clamp_raw(walk + step));
        end else begin
          step = longint'($urandom_range(0, 32'(2 * k)));
          step = step - k;
          walk = clamp_raw(walk + step);
          raw  = walk[23:0];
        end
      end else begin
        cmd = CMD_SAMPLE;
        raw = RAW_W'($urandom);
        if ($urandom_range(0, 3) == 0) raw = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h0;
      end
      send_paced(cmd, raw, vr);
    end
  endtask

  initial begin : stimulus
    sb           = new();
    burst_left   = 0;
    hold_request = 1'b0;
    rst      <= 1'b1;
    cfg_we   <= 1'b0;
    cfg_addr <= '0;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    for (int ph = 0; ph < PHASES; ph++) begin
      run_phase(ph, PHASE_ITEMS, (ph == 2 || ph == 5) ? 60 : -1);
    end

    // Let the last results settle
    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
